// ----- hw/rtl/mexp_pkg.sv -----
// Shared types for the modular exponentiation unit: controller commands and datapath status.
package mexp_pkg;

  // Operation run on the shared bit-serial modular multiplier
  typedef enum logic [1:0] {
    OP_REDUCE  = 2'd0,  // base mod modulus
    OP_MUL_RES = 2'd1,  // result * square mod modulus
    OP_SQUARE  = 2'd2   // square * square mod modulus
  } op_t;

  // Source of the final result
  typedef enum logic [1:0] {
    FIN_ONE  = 2'd0,
    FIN_BASE = 2'd1,
    FIN_ERR  = 2'd2,
    FIN_POW  = 2'd3
  } fin_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic mul_start;
    logic mul_step;
    logic write_back;
    logic fin;
    op_t  op;
    fin_t fin_sel;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic exp_zero;
    logic exp_one;
    logic mod_zero;
    logic e_zero;
    logic e_lsb;
    logic cnt_last;
  } status_t;

endpackage

// ----- hw/rtl/mexp_dp.sv -----
// Datapath: operand registers, bit-serial modular multiplier and result register.
module mexp_dp #(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [OPERAND_WIDTH-1:0] in_base,
  input  logic [OPERAND_WIDTH-1:0] in_exponent,
  input  logic [OPERAND_WIDTH-1:0] in_modulus,
  input  mexp_pkg::cmd_t           cmd,
  output mexp_pkg::status_t        status,
  output logic [OPERAND_WIDTH-1:0] out_result,
  output logic                     out_zero_modulus_error,
  output logic                     out_valid
);
  import mexp_pkg::*;

  localparam int W  = OPERAND_WIDTH;
  localparam int CW = $clog2(W);

  logic [W-1:0]  base_r, e_r, mod_r, res_r, sq_r, acc_r, ysh_r;
  logic [CW-1:0] cnt_r;
  logic [W-1:0]  out_result_r;
  logic          out_err_r;
  logic          out_valid_r;

  logic [W-1:0]  mul_x;
  logic [W:0]    dbl, dbl_red, sum, sum_red, mod_ext;
  logic [W-1:0]  acc_nxt;

  // Multiplicand for the current operation
  always_comb begin
    case (cmd.op)
      OP_REDUCE:  mul_x = W'(1);
      OP_MUL_RES: mul_x = res_r;
      OP_SQUARE:  mul_x = sq_r;
      default:    mul_x = sq_r;
    endcase
  end

  // One step: acc = 2*acc mod n, then + x mod n when the multiplier bit is set
  always_comb begin
    mod_ext = {1'b0, mod_r};
    dbl     = {acc_r, 1'b0};
    dbl_red = (dbl >= mod_ext) ? (dbl - mod_ext) : dbl;
    sum     = dbl_red + (ysh_r[W-1] ? {1'b0, mul_x} : '0);
    sum_red = (sum >= mod_ext) ? (sum - mod_ext) : sum;
    acc_nxt = sum_red[W-1:0];
  end

  // Operand and working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      base_r <= in_base;
      e_r    <= in_exponent;
      mod_r  <= in_modulus;
      res_r  <= (in_modulus == W'(1)) ? '0 : W'(1);
    end
    if (cmd.mul_start) begin
      acc_r <= '0;
      cnt_r <= '0;
      ysh_r <= (cmd.op == OP_REDUCE) ? base_r : sq_r;
    end else if (cmd.mul_step) begin
      acc_r <= acc_nxt;
      cnt_r <= cnt_r + CW'(1);
      ysh_r <= {ysh_r[W-2:0], 1'b0};
    end
    if (cmd.write_back) begin
      if (cmd.op == OP_MUL_RES) begin
        res_r <= acc_r;
      end else begin
        sq_r <= acc_r;
      end
      if (cmd.op == OP_SQUARE) begin
        e_r <= e_r >> 1;
      end
    end
    if (cmd.fin) begin
      case (cmd.fin_sel)
        FIN_ONE:  out_result_r <= W'(1);
        FIN_BASE: out_result_r <= base_r;
        FIN_ERR:  out_result_r <= '0;
        FIN_POW:  out_result_r <= res_r;
        default:  out_result_r <= res_r;
      endcase
      out_err_r <= (cmd.fin_sel == FIN_ERR);
    end
  end

  // Result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.fin;
    end
  end

  always_comb begin
    status.exp_zero = (e_r == '0);
    status.exp_one  = (e_r == W'(1));
    status.mod_zero = (mod_r == '0);
    status.e_zero   = (e_r == '0);
    status.e_lsb    = e_r[0];
    status.cnt_last = (cnt_r == CW'(W - 1));
  end

  assign out_result             = out_result_r;
  assign out_zero_modulus_error = out_err_r;
  assign out_valid              = out_valid_r;

endmodule

// ----- hw/rtl/mexp_ctrl.sv -----
// Controller: sequences reduction, multiply and square passes over the exponent bits.
module mexp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  mexp_pkg::status_t status,
  output mexp_pkg::cmd_t    cmd,
  output logic              busy
);
  import mexp_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_CHECK  = 6'b000010,
    S_MSTART = 6'b000100,
    S_MSTEP  = 6'b001000,
    S_WB     = 6'b010000,
    S_NEXT   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= OP_REDUCE;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    cmd         = '0;
    cmd.op      = op_r;
    cmd.fin_sel = FIN_POW;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      // special cases finish at once
      S_CHECK: begin
        if (status.exp_zero) begin
          cmd.fin     = 1'b1;
          cmd.fin_sel = FIN_ONE;
          state_nxt   = S_IDLE;
        end else if (status.exp_one) begin
          cmd.fin     = 1'b1;
          cmd.fin_sel = FIN_BASE;
          state_nxt   = S_IDLE;
        end else if (status.mod_zero) begin
          cmd.fin     = 1'b1;
          cmd.fin_sel = FIN_ERR;
          state_nxt   = S_IDLE;
        end else begin
          op_nxt    = OP_REDUCE;
          state_nxt = S_MSTART;
        end
      end
      S_MSTART: begin
        cmd.mul_start = 1'b1;
        state_nxt     = S_MSTEP;
      end
      S_MSTEP: begin
        cmd.mul_step = 1'b1;
        if (status.cnt_last) begin
          state_nxt = S_WB;
        end
      end
      // a multiply into the result is always followed by a squaring
      S_WB: begin
        cmd.write_back = 1'b1;
        if (op_r == OP_MUL_RES) begin
          op_nxt    = OP_SQUARE;
          state_nxt = S_MSTART;
        end else begin
          state_nxt = S_NEXT;
        end
      end
      S_NEXT: begin
        if (status.e_zero) begin
          cmd.fin     = 1'b1;
          cmd.fin_sel = FIN_POW;
          state_nxt   = S_IDLE;
        end else begin
          op_nxt    = status.e_lsb ? OP_MUL_RES : OP_SQUARE;
          state_nxt = S_MSTART;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

// ----- hw/rtl/modular_exponentiation_unit.sv -----
// Exponent 0 or 1 or a zero modulus finishes straight from the check, with no multiply.
// Otherwise the base is first reduced by the modulus, then each exponent bit runs a
// squaring pass, preceded by a multiply into the result when the bit is set, all on the
// shared bit-serial modular multiplier. One item at a time: busy stays high until the
// result is computed. The result is shown for one cycle with out_valid; no receiver stall.
// Reset (rst_n low, synchronous) returns the controller to idle and clears out_valid.
module modular_exponentiation_unit #(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [OPERAND_WIDTH-1:0] in_base,
  input  logic [OPERAND_WIDTH-1:0] in_exponent,
  input  logic [OPERAND_WIDTH-1:0] in_modulus,
  output logic                     out_valid,
  output logic [OPERAND_WIDTH-1:0] out_result,
  output logic                     out_zero_modulus_error
);
  import mexp_pkg::*;

  cmd_t    cmd;
  status_t status;

  mexp_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  mexp_dp #(
    .OPERAND_WIDTH(OPERAND_WIDTH)
  ) u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_base                (in_base),
    .in_exponent            (in_exponent),
    .in_modulus             (in_modulus),
    .cmd                    (cmd),
    .status                 (status),
    .out_result             (out_result),
    .out_zero_modulus_error (out_zero_modulus_error),
    .out_valid              (out_valid)
  );

endmodule

// ----- hw/rtl/mexp_checker.sv -----
// Port-level checks for the modular exponentiation unit, bound to the top level.
module mexp_checker #(
  parameter int OPERAND_WIDTH = 32
) (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     start,
  input logic                     busy,
  input logic                     out_valid,
  input logic [OPERAND_WIDTH-1:0] out_result,
  input logic                     out_zero_modulus_error
);

  // an accepted item keeps the unit busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("unit not busy after accepting an item");

  // busy only ever rises because an item was accepted
  a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a start");

  // the result strobe comes once the work is over, never twice in a row
  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!busy && !$past(out_valid)))
    else $error("result strobe while busy or repeated");

  // a zero modulus error carries a zero result
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_zero_modulus_error) |-> (out_result == '0))
    else $error("error flagged with nonzero result");

endmodule

bind modular_exponentiation_unit mexp_checker #(
  .OPERAND_WIDTH(OPERAND_WIDTH)
) u_mexp_checker (
  .clk                    (clk),
  .rst_n                  (rst_n),
  .start                  (start),
  .busy                   (busy),
  .out_valid              (out_valid),
  .out_result             (out_result),
  .out_zero_modulus_error (out_zero_modulus_error)
);

// ----- bench/testbench.sv -----
// Self-checking bench for the modular exponentiation unit: directed table, then random items.
`timescale 1ns / 1ps

module testbench;

  localparam int W = 32;
  localparam int RANDOM_ITEMS = 270;
  localparam int NUM_PHASES = 4;
  localparam longint CYCLE_LIMIT = 4000000;

  // Expected answer for one item
  typedef struct packed {
    logic [W-1:0] value;
    logic         zme;
  } answer_t;

  // One row of the directed table; typed rows carry their answer
  typedef struct packed {
    logic [W-1:0] base;
    logic [W-1:0] expo;
    logic [W-1:0] modulus;
    logic         typed;
    answer_t      answer;
  } vector_t;

  localparam int NUM_DIRECTED = 20;
  localparam vector_t DIRECTED [0:NUM_DIRECTED-1] = '{
    // exponent zero gives one whatever the modulus
    '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, '{32'd1, 1'b0}},
    '{32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001, 1'b1, '{32'd1, 1'b0}},
    '{32'h1234_5678, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, '{32'd1, 1'b0}},
    // exponent one passes the base through unreduced
    '{32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0005, 1'b1, '{32'hFFFF_FFFF, 1'b0}},
    '{32'h0000_0000, 32'h0000_0001, 32'h0000_0000, 1'b1, '{32'd0, 1'b0}},
    '{32'hA5A5_A5A5, 32'h0000_0001, 32'h0000_0001, 1'b1, '{32'hA5A5_A5A5, 1'b0}},
    // zero modulus with a real power flags an error
    '{32'h0000_0007, 32'h0000_0002, 32'h0000_0000, 1'b1, '{32'd0, 1'b1}},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{32'd0, 1'b1}},
    // modulus one always reduces to zero
    '{32'h0000_0003, 32'h0000_0002, 32'h0000_0001, 1'b1, '{32'd0, 1'b0}},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001, 1'b1, '{32'd0, 1'b0}},
    // easy powers
    '{32'h0000_0000, 32'h0000_0005, 32'h0000_0007, 1'b1, '{32'd0, 1'b0}},
    '{32'h0000_0002, 32'h0000_000A, 32'd1000, 1'b1, '{32'd24, 1'b0}},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{32'd0, 1'b0}},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b1, '{32'd1, 1'b0}},
    '{32'hFFFF_FFFE, 32'h0000_0002, 32'hFFFF_FFFF, 1'b1, '{32'd1, 1'b0}},
    // the rest go through the predictor
    '{32'h0000_0003, 32'hFFFF_FFFF, 32'hFFFF_FFFB, 1'b0, '{32'd0, 1'b0}},
    '{32'h1234_5678, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, '{32'd0, 1'b0}},
    '{32'hDEAD_BEEF, 32'h0000_0003, 32'h0000_0002, 1'b0, '{32'd0, 1'b0}},
    '{32'hFFFF_FFFF, 32'h0000_0002, 32'h8000_0001, 1'b0, '{32'd0, 1'b0}},
    '{32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAB, 1'b0, '{32'd0, 1'b0}}
  };

  // Sender idle percentage per phase
  localparam int IDLE_PCT [0:NUM_PHASES-1] = '{0, 73, 23, 0};

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         start = 1'b0;
  logic [W-1:0] in_base = '0;
  logic [W-1:0] in_exponent = '0;
  logic [W-1:0] in_modulus = '0;
  logic         busy;
  logic         out_valid;
  logic [W-1:0] out_result;
  logic         out_zero_modulus_error;

  answer_t power_q [$];
  int      mismatches = 0;
  longint  cycles = 0;

  modular_exponentiation_unit #(
    .OPERAND_WIDTH(W)
  ) u_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .start                 (start),
    .busy                  (busy),
    .in_base               (in_base),
    .in_exponent           (in_exponent),
    .in_modulus            (in_modulus),
    .out_valid             (out_valid),
    .out_result            (out_result),
    .out_zero_modulus_error(out_zero_modulus_error)
  );

  always #10 clk = ~clk;

  // Square-and-multiply with exact 64-bit products
  function automatic answer_t power_mod(logic [W-1:0] b, logic [W-1:0] e, logic [W-1:0] m);
    answer_t     a;
    logic [63:0] acc;
    logic [63:0] sq;
    logic [63:0] mod64;
    logic [W-1:0] k;
    a = '0;
    if (e == 0) begin
      a.value = 1;
    end else if (e == 1) begin
      a.value = b;
    end else if (m == 0) begin
      a.zme = 1'b1;
    end else begin
      mod64 = {32'd0, m};
      acc = 64'd1 % mod64;
      sq = {32'd0, b} % mod64;
      k = e;
      while (k != 0) begin
        if (k[0]) acc = (acc * sq) % mod64;
        sq = (sq * sq) % mod64;
        k = k >> 1;
      end
      a.value = acc[W-1:0];
    end
    return a;
  endfunction

  // Random item: mostly short exponents to keep runs fast, a few full-width
  function automatic vector_t random_item();
    vector_t v;
    int      sel;
    int      w;
    v = '0;
    sel = $urandom_range(99);
    if (sel < 10) v.base = '1;
    else if (sel < 15) v.base = '0;
    else v.base = $urandom;

    sel = $urandom_range(99);
    if (sel < 5) v.modulus = '0;
    else if (sel < 10) v.modulus = 1;
    else if (sel < 25) v.modulus = $urandom_range(2, 16);
    else if (sel < 30) v.modulus = '1;
    else v.modulus = $urandom;

    sel = $urandom_range(99);
    if (sel < 5) begin
      v.expo = 0;
    end else if (sel < 10) begin
      v.expo = 1;
    end else if (sel < 20) begin
      v.expo = $urandom;
    end else begin
      w = (sel < 25) ? $urandom_range(13, 31) : $urandom_range(2, 12);
      v.expo = ($urandom & ((32'd1 << w) - 1)) | (32'd1 << (w - 1));
    end
    return v;
  endfunction

  // Offer one item; returns at the edge where it was taken. start stays high.
  task automatic offer(input vector_t v, input int idle_pct);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while (busy || $urandom_range(99) < idle_pct);
    end
    start       <= 1'b1;
    in_base     <= v.base;
    in_exponent <= v.expo;
    in_modulus  <= v.modulus;
    do @(posedge clk); while (busy);
    power_q.push_back(v.typed ? v.answer : power_mod(v.base, v.expo, v.modulus));
  endtask

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (power_q.size() == 0) begin
        $display("%0t: unexpected item: result %h error %b", $time, out_result,
                 out_zero_modulus_error);
        mismatches++;
      end else begin
        if (out_result !== power_q[0].value) begin
          $display("%0t: result mismatch: expected %h got %h", $time, power_q[0].value,
                   out_result);
          mismatches++;
        end
        if (out_zero_modulus_error !== power_q[0].zme) begin
          $display("%0t: error flag mismatch: expected %b got %b", $time, power_q[0].zme,
                   out_zero_modulus_error);
          mismatches++;
        end
        void'(power_q.pop_front());
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Stimulus
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < NUM_DIRECTED; i++) offer(DIRECTED[i], 0);

    for (int p = 0; p < NUM_PHASES; p++) begin
      for (int i = 0; i < RANDOM_ITEMS / NUM_PHASES; i++) offer(random_item(), IDLE_PCT[p]);
    end
    start <= 1'b0;

    // Drain, then allow a few cycles for any stray strobe
    while (power_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/mexp_pkg.sv
hw/rtl/mexp_dp.sv
hw/rtl/mexp_ctrl.sv
hw/rtl/modular_exponentiation_unit.sv
hw/rtl/mexp_checker.sv
bench/testbench.sv
